/* hdl/descriptor_record_parser_macros.svh */
// Assertion macros for the descriptor record parser.
// Used by the top level; relies on its i_clk and i_rst_n ports.
`ifndef DESCRIPTOR_RECORD_PARSER_MACROS_SVH
`define DESCRIPTOR_RECORD_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define DRP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("descriptor_record_parser: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define DRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("descriptor_record_parser: next-cycle check failed");
`else
`define DRP_ASSERT_NOW(label, ante, cons)
`define DRP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* hdl/drp_pkg.sv */
// Shared types, constants and the CRC byte step for the descriptor record parser.
// No dependencies; the datapath, the controller and the top level use it.
package drp_pkg;

    localparam int MAX_STRIPS_DEF = 8;

    // Result status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
    localparam logic [2:0] ST_BAD_VERSION = 3'd2;
    localparam logic [2:0] ST_BAD_COUNT   = 3'd3;
    localparam logic [2:0] ST_BAD_CRC     = 3'd4;

    // Byte positions within a record.
    localparam logic [4:0] POS_VERSION = 5'd4;
    localparam logic [4:0] POS_COUNT   = 5'd5;
    localparam logic [4:0] POS_LIMIT   = 5'd8;
    localparam logic [4:0] POS_PAIRS   = 5'd12;
    localparam logic [4:0] POS_CRC     = 5'd28;
    localparam logic [4:0] POS_LAST    = 5'd31;

    localparam logic [7:0] VERSION_ONE = 8'd1;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    localparam logic [7:0] MAGIC [4] = '{8'h46, 8'h46, 8'h4C, 8'h59};

    typedef struct packed {
        logic       take_byte;
        logic       load_first;
        logic       load_next;
        logic [2:0] index;
    } t_cmd;

    typedef struct packed {
        logic frame_end;
        logic out_last;
    } t_stat;

    // One byte of the reflected CRC-32, bit by bit.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* hdl/drp_datapath.sv */
// Datapath of the descriptor record parser: byte position, CRC, checks,
// header fields, strip pair storage and the result register. Uses drp_pkg.
module drp_datapath #(
    parameter int MAX_STRIPS = drp_pkg::MAX_STRIPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  drp_pkg::t_cmd      i_cmd,
    input  logic [7:0]         i_data_byte,
    input  logic               i_frame_start,
    output drp_pkg::t_stat     o_stat,
    output logic [2:0]         o_status,
    output logic [31:0]        o_milliamps,
    output logic [3:0]         o_strip_total,
    output logic [2:0]         o_strip_index,
    output logic [7:0]         o_strip_leds,
    output logic [7:0]         o_flag_bits,
    output logic               o_last
);

    localparam int PAIR_AW = (MAX_STRIPS > 1) ? $clog2(MAX_STRIPS) : 1;

    logic [4:0]  r_pos;
    logic [31:0] r_crc;
    logic [2:0]  r_err;
    logic [7:0]  r_declared;
    logic [31:0] r_limit;
    logic [23:0] r_chk;
    logic [15:0] r_pair [MAX_STRIPS];

    logic [2:0]  r_status;
    logic [31:0] r_milliamps;
    logic [3:0]  r_total;
    logic [2:0]  r_index;
    logic [7:0]  r_led;
    logic [7:0]  r_flag;
    logic        r_last;

    logic [4:0]  pos;
    logic [31:0] crc_base;
    logic [2:0]  err_base;
    logic [2:0]  code;
    logic [2:0]  n_err;
    logic [2:0]  err_final;
    logic [31:0] n_crc;
    logic [4:0]  pair_off;
    logic [2:0]  pair_idx;
    logic        final_ok;
    logic [15:0] next_pair;

    assign pos      = i_frame_start ? 5'd0 : r_pos;
    assign crc_base = i_frame_start ? drp_pkg::CRC_INIT : r_crc;
    assign err_base = i_frame_start ? drp_pkg::ST_OK : r_err;

    always_comb begin
        code = drp_pkg::ST_OK;
        if (pos < drp_pkg::POS_VERSION) begin
            if (i_data_byte != drp_pkg::MAGIC[pos[1:0]]) code = drp_pkg::ST_BAD_MAGIC;
        end else if (pos == drp_pkg::POS_VERSION) begin
            if (i_data_byte != drp_pkg::VERSION_ONE) code = drp_pkg::ST_BAD_VERSION;
        end else if (pos == drp_pkg::POS_COUNT) begin
            if (i_data_byte == 8'd0 || i_data_byte > 8'(MAX_STRIPS)) begin
                code = drp_pkg::ST_BAD_COUNT;
            end
        end
    end

    // Only the first failure of a record is kept.
    assign n_err     = (err_base != drp_pkg::ST_OK) ? err_base : code;
    assign err_final = (n_err != drp_pkg::ST_OK) ? n_err :
                       (((crc_base ^ drp_pkg::CRC_INIT) == {i_data_byte, r_chk}) ?
                        drp_pkg::ST_OK : drp_pkg::ST_BAD_CRC);
    assign final_ok  = (err_final == drp_pkg::ST_OK);
    assign n_crc     = (pos < drp_pkg::POS_CRC) ? drp_pkg::crc_byte(crc_base, i_data_byte)
                                                : crc_base;
    assign pair_off  = pos - drp_pkg::POS_PAIRS;
    assign pair_idx  = pair_off[3:1];
    assign next_pair = r_pair[i_cmd.index[PAIR_AW-1:0]];

    assign o_stat.frame_end = (pos == drp_pkg::POS_LAST);
    assign o_stat.out_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 5'd0;
            r_crc <= drp_pkg::CRC_INIT;
            r_err <= drp_pkg::ST_OK;
        end else if (i_cmd.take_byte) begin
            if (o_stat.frame_end) begin
                r_pos <= 5'd0;
                r_crc <= drp_pkg::CRC_INIT;
                r_err <= drp_pkg::ST_OK;
            end else begin
                r_pos <= pos + 5'd1;
                r_crc <= n_crc;
                r_err <= n_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_byte) begin
            if (pos == drp_pkg::POS_COUNT) begin
                r_declared <= i_data_byte;
            end
            if (pos >= drp_pkg::POS_LIMIT && pos < drp_pkg::POS_PAIRS) begin
                r_limit[{pos[1:0], 3'b000} +: 8] <= i_data_byte;
            end
            if (pos >= drp_pkg::POS_PAIRS && pos < drp_pkg::POS_CRC
                && 4'(pair_idx) < 4'(MAX_STRIPS)) begin
                r_pair[pair_idx[PAIR_AW-1:0]][{pair_off[0], 3'b000} +: 8] <= i_data_byte;
            end
            if (pos >= drp_pkg::POS_CRC && pos < drp_pkg::POS_LAST) begin
                r_chk[{pos[1:0], 3'b000} +: 8] <= i_data_byte;
            end
        end
        if (i_cmd.load_first) begin
            r_status    <= err_final;
            r_milliamps <= final_ok ? r_limit : 32'd0;
            r_total     <= final_ok ? r_declared[3:0] : 4'd0;
            r_index     <= 3'd0;
            r_led       <= final_ok ? r_pair[0][7:0] : 8'd0;
            r_flag      <= final_ok ? r_pair[0][15:8] : 8'd0;
            r_last      <= !final_ok || (r_declared == 8'd1);
        end else if (i_cmd.load_next) begin
            r_index <= i_cmd.index;
            r_led   <= next_pair[7:0];
            r_flag  <= next_pair[15:8];
            r_last  <= ((4'(i_cmd.index) + 4'd1) == r_total);
        end
    end

    assign o_status      = r_status;
    assign o_milliamps   = r_milliamps;
    assign o_strip_total = r_total;
    assign o_strip_index = r_index;
    assign o_strip_leds  = r_led;
    assign o_flag_bits   = r_flag;
    assign o_last        = r_last;

endmodule

/* hdl/drp_ctrl.sv */
// Controller of the descriptor record parser: collect and emit states,
// both handshakes and the strip counter. Uses drp_pkg.
module drp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    output logic           o_valid,
    input  logic           i_stall,
    input  drp_pkg::t_stat i_stat,
    output drp_pkg::t_cmd  o_cmd
);

    typedef enum logic {S_COLLECT, S_EMIT} t_state;

    t_state     r_state;
    logic [2:0] r_index;
    logic [2:0] n_index;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_valid && (r_state == S_COLLECT);
    assign out_acc = (r_state == S_EMIT) && !i_stall;
    assign n_index = r_index + 3'd1;

    assign o_cmd.take_byte  = in_acc;
    assign o_cmd.load_first = in_acc && i_stat.frame_end;
    assign o_cmd.load_next  = out_acc && !i_stat.out_last;
    assign o_cmd.index      = n_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_index <= 3'd0;
        end else begin
            case (r_state)
                S_COLLECT: begin
                    if (o_cmd.load_first) begin
                        r_state <= S_EMIT;
                        r_index <= 3'd0;
                    end
                end
                S_EMIT: begin
                    if (out_acc) begin
                        if (i_stat.out_last) begin
                            r_state <= S_COLLECT;
                        end else begin
                            r_index <= n_index;
                        end
                    end
                end
                default: begin
                    r_state <= S_COLLECT;
                end
            endcase
        end
    end

    assign o_stall = (r_state == S_EMIT);
    assign o_valid = (r_state == S_EMIT);

endmodule

/* hdl/descriptor_record_parser.sv */
// Descriptor record parser, top level: links the controller and the datapath.
// Uses drp_pkg, drp_ctrl, drp_datapath and descriptor_record_parser_macros.svh.
//
// Usage: the input channel (i_valid, o_stall, i_data_byte, i_frame_start) takes
// one record byte per beat. A 32-byte record is checked for its magic tag,
// version, strip count and CRC-32, and a beat with i_frame_start high restarts
// the record at byte 0; after byte 31 the position wraps on its own.
// Bytes 0 to 30 give no result. The beat with byte 31 loads the result
// register, so the first result beat is shown on the next cycle. A good record
// gives one result beat per strip, one per cycle while the receiver does not
// stall; a failed record gives a single status beat. While results are shown,
// o_stall holds the input side off. A stall by the receiver (i_stall) holds the
// current result beat unchanged until it is taken. A synchronous active-low
// reset clears the byte position, the CRC and the error state and drops any
// results not yet delivered; no clearing pass is needed.
`include "descriptor_record_parser_macros.svh"

module descriptor_record_parser #(
    parameter int MAX_STRIPS = drp_pkg::MAX_STRIPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel: one record byte per beat.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_frame_start,
    // Result channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_milliamps,
    output logic [3:0]  o_strip_total,
    output logic [2:0]  o_strip_index,
    output logic [7:0]  o_strip_leds,
    output logic [7:0]  o_flag_bits,
    output logic        o_last
);

    drp_pkg::t_cmd  cmd;
    drp_pkg::t_stat stat;

    drp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    drp_datapath #(
        .MAX_STRIPS (MAX_STRIPS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_data_byte   (i_data_byte),
        .i_frame_start (i_frame_start),
        .o_stat        (stat),
        .o_status      (o_status),
        .o_milliamps   (o_milliamps),
        .o_strip_total (o_strip_total),
        .o_strip_index (o_strip_index),
        .o_strip_leds  (o_strip_leds),
        .o_flag_bits   (o_flag_bits),
        .o_last        (o_last)
    );

    // Input is held off whenever a result beat is on offer.
    `DRP_ASSERT_NOW(a_stall_while_emit, o_valid, o_stall)
    // A failed record ends with its single status beat.
    `DRP_ASSERT_NOW(a_error_is_last, o_valid && (o_status != drp_pkg::ST_OK), o_last)
    // A good result describes a strip inside the declared count.
    `DRP_ASSERT_NOW(a_index_in_range, o_valid && (o_status == drp_pkg::ST_OK),
                    (4'(o_strip_index) < o_strip_total) && (o_strip_total <= 4'(MAX_STRIPS)))
    // After a non-final result is taken, the next strip follows at once.
    `DRP_ASSERT_NEXT(a_strip_advance, o_valid && !i_stall && !o_last,
                     o_valid && (o_strip_index == 3'($past(o_strip_index) + 3'd1)))

endmodule
